[sv/ght_pkg.sv]
// Shared types, codes and the size-class function of the generational handle table.
package ght_pkg;

	// Table geometry
	localparam int CAPACITY_DEF = 1024;

	// Request codes
	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_CHECK = 2'd2;

	// Status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NULL     = 3'd1;
	localparam logic [2:0] ST_RANGE    = 3'd2;
	localparam logic [2:0] ST_NOT_LIVE = 3'd3;
	localparam logic [2:0] ST_GEN      = 3'd4;
	localparam logic [2:0] ST_VIEW     = 3'd5;
	localparam logic [2:0] ST_FULL     = 3'd6;

	// Size-class limits
	localparam logic [4:0]  CLASS_LARGE = 5'd17;
	localparam logic [31:0] ALIGN_DEF   = 32'd8;
	localparam logic [31:0] FINE_MAX    = 32'd112;
	localparam logic [31:0] MID_MAX     = 32'd65536;
	localparam int          MID_LG_MIN  = 7;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	// One table entry as stored in the entry memory
	typedef struct packed {
		logic        live;
		logic [31:0] gen;
		logic [31:0] size;
		logic [31:0] align;
		logic [4:0]  cls;
	} entry_t;

	// Registered request with its precomputed view length and class
	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] size;
		logic [31:0] align;
		logic [9:0]  index;
		logic [31:0] gen;
		logic [63:0] need;
		logic [4:0]  cls;
	} req_t;

	// Size class of n = max(size, effective align)
	function automatic logic [4:0] class_of(input logic [31:0] n);
		logic [31:0] m;
		logic [4:0]  lg;
		m  = n - 32'd1;
		lg = 5'(MID_LG_MIN);
		for (int i = MID_LG_MIN; i < 16; i++) begin
			if (m[i]) begin
				lg = 5'(i + 1);
			end
		end
		if (n == 32'd0) begin
			class_of = 5'd0;
		end else if (n <= FINE_MAX) begin
			class_of = {2'b00, m[6:4]};
		end else if (n > MID_MAX) begin
			class_of = CLASS_LARGE;
		end else begin
			class_of = lg;
		end
	endfunction

endpackage

[sv/ght_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
module ght_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, hold data between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/ght_req_stage.sv]
// Request register with the view-length multiply and the size-class lookup.
module ght_req_stage (
	input  logic              clk,
	input  logic              load,
	input  logic [1:0]        req_type,
	input  logic [31:0]       req_size,
	input  logic [31:0]       req_align,
	input  logic [9:0]        handle_index,
	input  logic [31:0]       handle_gen,
	input  logic [31:0]       elem_bytes,
	input  logic [31:0]       elem_count,
	output ght_pkg::req_t     req_s1
);

	logic [31:0] align_eff;
	logic [31:0] class_n;

	// Resolve default alignment and the class operand
	always_comb begin
		align_eff = (req_align == 32'd0) ? ght_pkg::ALIGN_DEF : req_align;
		class_n   = (align_eff > req_size) ? align_eff : req_size;
	end

	// Capture the beat
	always_ff @(posedge clk) begin
		if (load) begin
			req_s1.req_type <= req_type;
			req_s1.size     <= req_size;
			req_s1.align    <= req_align;
			req_s1.index    <= handle_index;
			req_s1.gen      <= handle_gen;
			req_s1.need     <= {32'd0, elem_count} * {32'd0, elem_bytes};
			req_s1.cls      <= ght_pkg::class_of(class_n);
		end
	end

endmodule

[sv/generational_handle_table_unit.sv]
// Generational handle table: sequencer, entry and recycle-stack memories, output register.
// A taken request is registered, and execute loads its result into the output register.
// Requests are taken only in idle, not during execute's entry read-then-write.
// A waiting result stalls the sequencer only when a second result is ready to leave.
// Reset clears control registers at once; no clearing pass runs, since slot zero and any
// slot at or above the fresh-slot counter read as not live with generation zero.
module generational_handle_table_unit #(
	parameter int CAPACITY = ght_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] req_size,
	input  logic [31:0] req_align,
	input  logic [9:0]  handle_index,
	input  logic [31:0] handle_gen,
	input  logic [31:0] elem_bytes,
	input  logic [31:0] elem_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [9:0]  out_index,
	output logic [31:0] out_gen,
	output logic [4:0]  out_class,
	output logic [31:0] out_bytes
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int SW = AW + 32;
	localparam int EW = $bits(ght_pkg::entry_t);

	ght_pkg::state_t state_q;
	ght_pkg::req_t   req_s1;
	ght_pkg::entry_t ent_rd;
	ght_pkg::entry_t ent_wd;

	logic [CW-1:0] rc_q;
	logic [CW-1:0] fresh_q;
	logic          accept;
	logic          advance;

	logic          ent_we;
	logic [AW-1:0] ent_waddr;
	logic [AW-1:0] ent_raddr;
	logic [EW-1:0] ent_rdata;
	logic          stk_we;
	logic [AW-1:0] stk_waddr;
	logic [SW-1:0] stk_wdata;
	logic [AW-1:0] stk_raddr;
	logic [SW-1:0] stk_rdata;

	logic [31:0]   idx_in32;
	logic [31:0]   idx_s1_32;
	logic          known;
	logic          live;
	logic [31:0]   cur_gen;
	logic [2:0]    hstat;

	logic [2:0]    st_d;
	logic [9:0]    oidx_d;
	logic [31:0]   ogen_d;
	logic [4:0]    ocls_d;
	logic [31:0]   obytes_d;
	logic [CW-1:0] rc_d;
	logic [CW-1:0] fresh_d;
	logic [AW-1:0] slot;

	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [9:0]    out_index_q;
	logic [31:0]   out_gen_q;
	logic [4:0]    out_class_q;
	logic [31:0]   out_bytes_q;

	// Handshake
	assign in_ready = (state_q == ght_pkg::S_IDLE);
	assign accept   = in_valid && in_ready;
	assign advance  = (state_q == ght_pkg::S_EXEC) && (!out_valid_q || out_ready);

	// Request register
	ght_req_stage u_req (
		.clk          (clk),
		.load         (accept),
		.req_type     (req_type),
		.req_size     (req_size),
		.req_align    (req_align),
		.handle_index (handle_index),
		.handle_gen   (handle_gen),
		.elem_bytes   (elem_bytes),
		.elem_count   (elem_count),
		.req_s1       (req_s1)
	);

	// Read addresses issued on the request beat
	assign idx_in32  = 32'(handle_index);
	assign ent_raddr = idx_in32[AW-1:0];
	assign stk_raddr = AW'(rc_q - CW'(1));

	ght_ram #(.WIDTH(EW), .DEPTH(CAPACITY), .AW(AW)) u_entry_mem (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wd),
		.re    (accept),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	ght_ram #(.WIDTH(SW), .DEPTH(CAPACITY), .AW(AW)) u_stack_mem (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (accept),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	assign ent_rd = ght_pkg::entry_t'(ent_rdata);

	// Validate the handle; slot zero and slots never handed out read as not live
	always_comb begin
		idx_s1_32 = 32'(req_s1.index);
		known     = (req_s1.index != 10'd0) && (idx_s1_32 < 32'(fresh_q));
		live      = known && ent_rd.live;
		cur_gen   = known ? ent_rd.gen : 32'd0;
		if (req_s1.index == 10'd0 && req_s1.gen == 32'd0) begin
			hstat = ght_pkg::ST_NULL;
		end else if (idx_s1_32 >= 32'(CAPACITY)) begin
			hstat = ght_pkg::ST_RANGE;
		end else if (!live) begin
			hstat = ght_pkg::ST_NOT_LIVE;
		end else if (cur_gen != req_s1.gen) begin
			hstat = ght_pkg::ST_GEN;
		end else begin
			hstat = ght_pkg::ST_OK;
		end
	end

	// Execute: form the result and the write-back
	always_comb begin
		st_d      = ght_pkg::ST_OK;
		oidx_d    = 10'd0;
		ogen_d    = 32'd0;
		ocls_d    = 5'd0;
		obytes_d  = 32'd0;
		rc_d      = rc_q;
		fresh_d   = fresh_q;
		slot      = fresh_q[AW-1:0];
		ent_we    = 1'b0;
		ent_waddr = idx_s1_32[AW-1:0];
		ent_wd    = '0;
		stk_we    = 1'b0;
		stk_waddr = rc_q[AW-1:0];
		stk_wdata = {idx_s1_32[AW-1:0], cur_gen + 32'd1};
		case (req_s1.req_type)
			ght_pkg::REQ_ALLOC: begin
				if (rc_q != CW'(0)) begin
					slot   = stk_rdata[SW-1:32];
					ogen_d = stk_rdata[31:0];
					rc_d   = rc_q - CW'(1);
				end else if (fresh_q < CW'(CAPACITY)) begin
					slot    = fresh_q[AW-1:0];
					ogen_d  = 32'd0;
					fresh_d = fresh_q + CW'(1);
				end else begin
					st_d = ght_pkg::ST_FULL;
				end
				if (st_d == ght_pkg::ST_OK) begin
					oidx_d       = 10'(32'(slot));
					ocls_d       = req_s1.cls;
					ent_we       = advance;
					ent_waddr    = slot;
					ent_wd.live  = 1'b1;
					ent_wd.gen   = ogen_d;
					ent_wd.size  = req_s1.size;
					ent_wd.align = (req_s1.align == 32'd0) ? ght_pkg::ALIGN_DEF
					                                       : req_s1.align;
					ent_wd.cls   = req_s1.cls;
				end else begin
					ogen_d = 32'd0;
				end
			end
			ght_pkg::REQ_FREE: begin
				st_d = hstat;
				if (hstat == ght_pkg::ST_OK) begin
					ocls_d     = ent_rd.cls;
					obytes_d   = ent_rd.size;
					ent_we     = advance;
					ent_wd.gen = cur_gen + 32'd1;
					if (rc_q < CW'(CAPACITY)) begin
						stk_we = advance;
						rc_d   = rc_q + CW'(1);
					end
				end
			end
			ght_pkg::REQ_CHECK: begin
				st_d = hstat;
				if (hstat == ght_pkg::ST_OK) begin
					if (req_s1.need > {32'd0, ent_rd.size} || req_s1.align > ent_rd.align) begin
						st_d = ght_pkg::ST_VIEW;
					end else begin
						obytes_d = req_s1.need[31:0];
					end
				end
			end
			default: begin
				st_d = ght_pkg::ST_OK;
			end
		endcase
	end

	// Sequencer and table counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ght_pkg::S_IDLE;
			rc_q    <= '0;
			fresh_q <= CW'(1);
		end else begin
			case (state_q)
				ght_pkg::S_IDLE: begin
					if (accept) begin
						state_q <= ght_pkg::S_EXEC;
					end
				end
				ght_pkg::S_EXEC: begin
					if (advance) begin
						state_q <= ght_pkg::S_IDLE;
						rc_q    <= rc_d;
						fresh_q <= fresh_d;
					end
				end
				default: begin
					state_q <= ght_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Output valid: set on a finished request, drop on the taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (advance) begin
			status_q    <= st_d;
			out_index_q <= oidx_d;
			out_gen_q   <= ogen_d;
			out_class_q <= ocls_d;
			out_bytes_q <= obytes_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_index = out_index_q;
	assign out_gen   = out_gen_q;
	assign out_class = out_class_q;
	assign out_bytes = out_bytes_q;

`ifndef SYNTH
	a_fresh_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q >= CW'(1) && fresh_q <= CW'(CAPACITY))
		else $error("fresh slot counter out of bounds");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rc_q < fresh_q)
		else $error("more recycled slots than slots handed out");

	a_fresh_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(fresh_q) |-> fresh_q == $past(fresh_q) + CW'(1))
		else $error("fresh slot counter moved by other than one");

	a_exec_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ght_pkg::S_EXEC && !in_ready)
		else $error("request beat not followed by execute");
`endif

endmodule

[bench/tb.sv]
// Testbench for the generational handle table: shadow table, request driver and reply checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          SLOTS           = ght_pkg::CAPACITY_DEF;
	localparam logic [1:0]  REQ_UNUSED      = 2'd3;
	localparam int unsigned RANDOM_ITEMS    = 1325;
	localparam int unsigned PRESSURE_AT     = 200;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES    = 8;
	localparam int unsigned CYCLE_LIMIT     = 1000000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] req_bytes;
		logic [31:0] req_align;
		logic [9:0]  slot;
		logic [31:0] gen;
		logic [31:0] elem_bytes;
		logic [31:0] elem_count;
	} request_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [9:0]  slot;
		logic [31:0] gen;
		logic [4:0]  cls;
		logic [31:0] bytes;
	} reply_t;

	// Shadow copy of the table; every accepted request queues the reply it owes
	class handle_table_shadow;
		bit          live [SLOTS];
		bit [31:0]   gen_of [SLOTS];
		bit [31:0]   size_of [SLOTS];
		bit [31:0]   align_of [SLOTS];
		bit [4:0]    class_of_slot [SLOTS];
		bit [9:0]    recycle_stack [SLOTS];
		int unsigned recycle_depth;
		int unsigned fresh_slot;
		int unsigned full_hits;
		int unsigned errors;
		reply_t      owed_replies [$];

		function new();
			recycle_depth = 0;
			fresh_slot    = 1;
			full_hits     = 0;
			errors        = 0;
		endfunction

		// Bucket by the larger of size and alignment
		function bit [4:0] bucket_of(bit [31:0] req_bytes, bit [31:0] req_align);
			bit [32:0] n;
			bit [32:0] p;
			bit [4:0]  lg;
			n = 33'(req_bytes);
			if (req_align > req_bytes) n = 33'(req_align);
			if (n == 0) n = 33'(16);
			if (n <= ght_pkg::FINE_MAX) return 5'((n + 15) / 16 - 1);
			if (n > ght_pkg::MID_MAX) return ght_pkg::CLASS_LARGE;
			p  = 33'(128);
			lg = 5'd7;
			while (p < n) begin
				p = p << 1;
				lg++;
			end
			return lg;
		endfunction

		// Validate in order: null, range, live, generation
		function bit [2:0] handle_status(bit [9:0] slot, bit [31:0] gen);
			if (slot == 0 && gen == 0) return ght_pkg::ST_NULL;
			if (slot >= SLOTS) return ght_pkg::ST_RANGE;
			if (!live[slot]) return ght_pkg::ST_NOT_LIVE;
			if (gen_of[slot] != gen) return ght_pkg::ST_GEN;
			return ght_pkg::ST_OK;
		endfunction

		function void take_request(request_t r);
			reply_t    y;
			bit [9:0]  slot;
			bit        have;
			bit [31:0] eff_align;
			bit [63:0] need;
			y = '0;
			case (r.kind)
				ght_pkg::REQ_ALLOC: begin
					// Recycled slots first, newest on top; then fresh ones
					have = 1'b1;
					slot = '0;
					if (recycle_depth > 0) begin
						recycle_depth--;
						slot = recycle_stack[recycle_depth];
					end else if (fresh_slot < SLOTS) begin
						slot = 10'(fresh_slot);
						fresh_slot++;
					end else begin
						have = 1'b0;
					end
					if (!have) begin
						y.status = ght_pkg::ST_FULL;
						full_hits++;
					end else begin
						eff_align = (r.req_align == 0) ? ght_pkg::ALIGN_DEF : r.req_align;
						size_of[slot]       = r.req_bytes;
						align_of[slot]      = eff_align;
						class_of_slot[slot] = bucket_of(r.req_bytes, eff_align);
						live[slot]          = 1'b1;
						y.slot              = slot;
						y.gen               = gen_of[slot];
						y.cls               = class_of_slot[slot];
					end
				end
				ght_pkg::REQ_FREE: begin
					y.status = handle_status(r.slot, r.gen);
					if (y.status == ght_pkg::ST_OK) begin
						y.cls                 = class_of_slot[r.slot];
						y.bytes               = size_of[r.slot];
						live[r.slot]          = 1'b0;
						size_of[r.slot]       = '0;
						align_of[r.slot]      = '0;
						class_of_slot[r.slot] = '0;
						gen_of[r.slot]        = gen_of[r.slot] + 1;
						if (recycle_depth < SLOTS) begin
							recycle_stack[recycle_depth] = r.slot;
							recycle_depth++;
						end
					end
				end
				ght_pkg::REQ_CHECK: begin
					y.status = handle_status(r.slot, r.gen);
					if (y.status == ght_pkg::ST_OK) begin
						// Full 64-bit view length
						need = 64'(r.elem_count) * 64'(r.elem_bytes);
						if (need > 64'(size_of[r.slot]) || r.req_align > align_of[r.slot])
							y.status = ght_pkg::ST_VIEW;
						else
							y.bytes = need[31:0];
					end
				end
				default: begin
				end
			endcase
			owed_replies.push_back(y);
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			if (owed_replies.size() == 0) begin
				$error("reply beat with nothing owed: status %0d", got.status);
				errors++;
				return;
			end
			want = owed_replies.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.slot !== want.slot) begin
				$error("out_index: expected %0d, got %0d", want.slot, got.slot);
				errors++;
			end
			if (got.gen !== want.gen) begin
				$error("out_gen: expected %0d, got %0d", want.gen, got.gen);
				errors++;
			end
			if (got.cls !== want.cls) begin
				$error("out_class: expected %0d, got %0d", want.cls, got.cls);
				errors++;
			end
			if (got.bytes !== want.bytes) begin
				$error("out_bytes: expected %0d, got %0d", want.bytes, got.bytes);
				errors++;
			end
		endfunction
	endclass

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic [1:0]  req_type     = '0;
	logic [31:0] req_size     = '0;
	logic [31:0] req_align    = '0;
	logic [9:0]  handle_index = '0;
	logic [31:0] handle_gen   = '0;
	logic [31:0] elem_bytes   = '0;
	logic [31:0] elem_count   = '0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [2:0]  status;
	logic [9:0]  out_index;
	logic [31:0] out_gen;
	logic [4:0]  out_class;
	logic [31:0] out_bytes;

	handle_table_shadow shadow;
	int unsigned        sent_count  = 0;
	int unsigned        cycle_count = 0;
	bit                 hold_off_ask = 1'b0;
	bit                 hold_active  = 1'b0;

	generational_handle_table_unit #(
		.CAPACITY(SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.req_size(req_size),
		.req_align(req_align),
		.handle_index(handle_index),
		.handle_gen(handle_gen),
		.elem_bytes(elem_bytes),
		.elem_count(elem_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_index(out_index),
		.out_gen(out_gen),
		.out_class(out_class),
		.out_bytes(out_bytes)
	);

	always #5 clk = ~clk;

	// Idle length: mostly none, some short, a few long
	function automatic int unsigned pause_length();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 65) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic request_t make_req(logic [1:0] kind, logic [31:0] req_bytes,
			logic [31:0] req_align, logic [9:0] slot, logic [31:0] gen,
			logic [31:0] esz, logic [31:0] ecnt);
		request_t r;
		r.kind       = kind;
		r.req_bytes  = req_bytes;
		r.req_align  = req_align;
		r.slot       = slot;
		r.gen        = gen;
		r.elem_bytes = esz;
		r.elem_count = ecnt;
		return r;
	endfunction

	// Random request shaped by the shadow table: fill first, then mix
	function automatic request_t next_request();
		request_t    r;
		int unsigned roll;
		int unsigned pick;
		int unsigned top;
		bit [31:0]   stored_size;
		bit [31:0]   stored_align;
		bit [31:0]   max_cnt;
		bit [31:0]   p;
		r = make_req(2'($urandom_range(0, 3)), $urandom, $urandom,
			10'($urandom_range(0, 1023)), $urandom, $urandom, $urandom);
		roll = $urandom_range(0, 99);
		if (shadow.full_hits < 3) begin
			r.kind = (roll < 92) ? ght_pkg::REQ_ALLOC : (roll < 96) ? ght_pkg::REQ_FREE :
				(roll < 99) ? ght_pkg::REQ_CHECK : REQ_UNUSED;
		end else begin
			r.kind = (roll < 20) ? ght_pkg::REQ_ALLOC : (roll < 55) ? ght_pkg::REQ_FREE :
				(roll < 95) ? ght_pkg::REQ_CHECK : REQ_UNUSED;
		end

		if (r.kind == ght_pkg::REQ_ALLOC) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				r.req_bytes = $urandom_range(0, 112);
			end else if (pick < 50) begin
				r.req_bytes = $urandom_range(113, 65536);
			end else if (pick < 62) begin
				// Straddle a power of two
				p = 32'd1 << $urandom_range(0, 16);
				r.req_bytes = p + $urandom_range(0, 2) - 1;
			end else if (pick < 80) begin
				r.req_bytes = $urandom_range(65537, 32'hFFFF_FFFF);
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) r.req_align = '0;
			else if (pick < 80) r.req_align = 32'd1 << $urandom_range(0, 16);
			else if (pick < 88) r.req_align = 32'd1 << $urandom_range(17, 31);
		end

		if (r.kind == ght_pkg::REQ_FREE || r.kind == ght_pkg::REQ_CHECK) begin
			// Mostly handles of allocated slots, some stale or bogus
			pick = $urandom_range(0, 99);
			top  = (shadow.fresh_slot > 1) ? shadow.fresh_slot - 1 : 1;
			if (pick < 86) begin
				r.slot = 10'($urandom_range(1, top));
				r.gen  = shadow.gen_of[r.slot];
				if (pick >= 80) r.gen = r.gen + $urandom_range(1, 2);
			end else if (pick < 90) begin
				r.slot = '0;
				r.gen  = '0;
			end else if (pick < 94) begin
				r.slot = '0;
			end
		end

		if (r.kind == ght_pkg::REQ_CHECK) begin
			stored_size  = shadow.size_of[r.slot];
			stored_align = shadow.align_of[r.slot];
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				r.elem_bytes = 32'd1 << $urandom_range(0, 4);
				max_cnt      = stored_size / r.elem_bytes;
				if (pick < 55) begin
					r.elem_count = $urandom_range(0, max_cnt);
					r.req_align  = $urandom_range(0, stored_align);
				end else if (pick < 70) begin
					r.elem_count = max_cnt + 1;
					r.req_align  = '0;
				end else begin
					r.elem_count = $urandom_range(0, 3);
					r.req_align  = stored_align + 1;
				end
			end
		end
		return r;
	endfunction

	// Offer one beat and hold it until taken
	task automatic send_request(request_t r);
		int unsigned gap;
		gap = (hold_active || (sent_count % 300) < 50) ? 0 : pause_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= r.kind;
		req_size     <= r.req_bytes;
		req_align    <= r.req_align;
		handle_index <= r.slot;
		handle_gen   <= r.gen;
		elem_bytes   <= r.elem_bytes;
		elem_count   <= r.elem_count;
		do @(posedge clk); while (!in_ready);
		shadow.take_request(r);
		sent_count++;
	endtask

	// Stimulus: reset, directed opening, random body, drain
	initial begin
		request_t    opening [$];
		request_t    r;
		int unsigned counted;
		shadow  = new();
		counted = 0;

		// Allocation classes at their edges
		opening.push_back(make_req(ght_pkg::REQ_ALLOC, 32'd0, 32'd0, '0, '0, '0, '0));
		opening.push_back(make_req(ght_pkg::REQ_ALLOC, 32'd112, 32'd1, '0, '0, '0, '0));
		opening.push_back(make_req(ght_pkg::REQ_ALLOC, 32'd113, 32'd16, '0, '0, '0, '0));
		opening.push_back(make_req(ght_pkg::REQ_ALLOC, 32'd65536, 32'd8, '0, '0, '0, '0));
		opening.push_back(make_req(ght_pkg::REQ_ALLOC, 32'd65537, 32'd0, '0, '0, '0, '0));
		opening.push_back(make_req(ght_pkg::REQ_ALLOC, '1, '1, '0, '0, '0, '0));
		opening.push_back(make_req(ght_pkg::REQ_ALLOC, 32'd16, 32'd128, '0, '0, '0, '0));
		// Views: empty, 64-bit overflow, full length, misaligned, exact, one over
		opening.push_back(make_req(ght_pkg::REQ_CHECK, '0, '0, 10'd1, '0, '0, '0));
		opening.push_back(make_req(ght_pkg::REQ_CHECK, '0, '0, 10'd6, '0, '1, '1));
		opening.push_back(make_req(ght_pkg::REQ_CHECK, '0, '1, 10'd6, '0, 32'd1, '1));
		opening.push_back(make_req(ght_pkg::REQ_CHECK, '0, 32'd2, 10'd2, '0, 32'd1, 32'd1));
		opening.push_back(make_req(ght_pkg::REQ_CHECK, '0, 32'd1, 10'd2, '0, 32'd16, 32'd7));
		opening.push_back(make_req(ght_pkg::REQ_CHECK, '0, 32'd1, 10'd2, '0, 32'd16, 32'd8));
		// Null handle and slot zero with a nonzero generation
		opening.push_back(make_req(ght_pkg::REQ_CHECK, '0, '0, 10'd0, '0, '0, '0));
		opening.push_back(make_req(ght_pkg::REQ_FREE, '0, '0, 10'd0, '0, '0, '0));
		opening.push_back(make_req(ght_pkg::REQ_CHECK, '0, '0, 10'd0, 32'd5, '0, '0));
		// Top slot never allocated, stale generation, good free, double free
		opening.push_back(make_req(ght_pkg::REQ_FREE, '0, '0, 10'd1023, '0, '0, '0));
		opening.push_back(make_req(ght_pkg::REQ_FREE, '0, '0, 10'd3, 32'd1, '0, '0));
		opening.push_back(make_req(ght_pkg::REQ_FREE, '0, '0, 10'd3, '0, '0, '0));
		opening.push_back(make_req(ght_pkg::REQ_FREE, '0, '0, 10'd3, '0, '0, '0));
		opening.push_back(make_req(ght_pkg::REQ_CHECK, '0, '0, 10'd3, 32'd1, '0, '0));
		opening.push_back(make_req(ght_pkg::REQ_FREE, '0, '0, 10'd5, '0, '0, '0));
		// Recycled slots come back newest first with bumped generations
		opening.push_back(make_req(ght_pkg::REQ_ALLOC, 32'd40, '0, '0, '0, '0, '0));
		opening.push_back(make_req(ght_pkg::REQ_ALLOC, 32'd200, '0, '0, '0, '0, '0));
		opening.push_back(make_req(REQ_UNUSED, $urandom, $urandom, 10'($urandom),
			$urandom, $urandom, $urandom));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[k]) send_request(opening[k]);

		while (counted < RANDOM_ITEMS) begin
			r = next_request();
			send_request(r);
			if (r.kind != REQ_UNUSED) begin
				counted++;
				if (counted == PRESSURE_AT) hold_off_ask = 1'b1;
			end
		end
		in_valid <= 1'b0;

		// Drain owed replies, then let the pipeline settle
		while (shadow.owed_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (shadow.errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	// Reply side: check each taken beat, stall at random, hold off once for long
	initial begin
		int unsigned stall_left;
		reply_t      got;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got = {status, out_index, out_gen, out_class, out_bytes};
				shadow.check_reply(got);
			end
			if (hold_off_ask) begin
				hold_off_ask = 1'b0;
				hold_active  = 1'b1;
				stall_left   = HOLD_OFF_CYCLES;
			end else if (stall_left == 0) begin
				hold_active = 1'b0;
				if (((cycle_count / 700) % 5) != 1) stall_left = pause_length();
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: FAIL");
		$finish;
	end

endmodule
